/* hw/rtl/rkrf_pkg.sv */
// ----------------------------------------------------------------------------
// rkrf_pkg
// Shared types and constants of the remote key repeat filter: report header
// values, register indexes and reset values, and the structs between stages.
// ----------------------------------------------------------------------------
package rkrf_pkg;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned KEY_W       = 8;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned LENGTH_W    = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_WINDOW = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_DELAY  = 8'd1;

   localparam logic [CSR_DATA_W-1:0] REPEAT_WINDOW_RESET = 16'd300;
   localparam logic [CSR_DATA_W-1:0] REPEAT_DELAY_RESET  = 16'd500;

   localparam logic [LENGTH_W-1:0] GOOD_LENGTH = 6'd6;
   localparam logic [7:0]          HEAD_ZERO   = 8'h00;
   localparam logic [7:0]          HEAD_ONE    = 8'h06;
   localparam logic [7:0]          HEAD_THREE  = 8'h0a;
   localparam logic [COUNT_W-1:0]  MIN_REPEATS = 8'd5;
   localparam logic [COUNT_W-1:0]  COUNT_MAX   = 8'hff;

   typedef struct packed {
      logic [LENGTH_W-1:0] report_length;
      logic [7:0]          head_byte_zero;
      logic [7:0]          head_byte_one;
      logic [KEY_W-1:0]    key_byte;
      logic [7:0]          head_byte_three;
      logic [TIME_W-1:0]   arrival_ms;
   } report_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] repeat_window_ms;
      logic [CSR_DATA_W-1:0] repeat_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic             load;
      logic [KEY_W-1:0] key;
   } result_type;

endpackage

/* hw/rtl/rkrf_channels.sv */
// ----------------------------------------------------------------------------
// rkrf channels
// Valid/ready channels of the filter: report requests and key responses.
// ----------------------------------------------------------------------------
interface rkrf_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] report_length;
   logic [7:0] head_byte_zero;
   logic [7:0] head_byte_one;
   logic [7:0] key_byte;
   logic [7:0] head_byte_three;
   logic [31:0] arrival_ms;

   modport source (
      output valid, report_length, head_byte_zero, head_byte_one,
             key_byte, head_byte_three, arrival_ms,
      input  ready
   );
   modport sink (
      input  valid, report_length, head_byte_zero, head_byte_one,
             key_byte, head_byte_three, arrival_ms,
      output ready
   );
endinterface

interface rkrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_event;

   modport source (output valid, key_event, input ready);
   modport sink (input valid, key_event, output ready);
endinterface

/* hw/rtl/rkrf_csr.sv */
// ----------------------------------------------------------------------------
// rkrf_csr
// Configuration registers: repeat window and repeat delay in milliseconds.
// ----------------------------------------------------------------------------
module rkrf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [rkrf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rkrf_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output rkrf_pkg::cfg_type                  cfg
);

   rkrf_pkg::cfg_type cfg_ff;
   rkrf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rkrf_pkg::CSR_REPEAT_WINDOW: cfg_in.repeat_window_ms = csr_write_data;
            rkrf_pkg::CSR_REPEAT_DELAY:  cfg_in.repeat_delay_ms  = csr_write_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_window_ms <= rkrf_pkg::REPEAT_WINDOW_RESET;
         cfg_ff.repeat_delay_ms  <= rkrf_pkg::REPEAT_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/rkrf_input_stage.sv */
// ----------------------------------------------------------------------------
// rkrf_input_stage
// Input register: holds one report until the filter core takes it.
// ----------------------------------------------------------------------------
module rkrf_input_stage (
   input  logic                 clock,
   input  logic                 reset,
   rkrf_req_if.sink             req_chan,
   input  logic                 take,
   output logic                 held_valid,
   output rkrf_pkg::report_type held_report
);

   logic                 valid_ff;
   logic                 valid_in;
   rkrf_pkg::report_type report_ff;
   rkrf_pkg::report_type report_in;
   logic                 transfer;

   assign req_chan.ready = !valid_ff || take;
   assign transfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in  = valid_ff;
      report_in = report_ff;
      if (transfer) begin
         valid_in                  = 1'b1;
         report_in.report_length   = req_chan.report_length;
         report_in.head_byte_zero  = req_chan.head_byte_zero;
         report_in.head_byte_one   = req_chan.head_byte_one;
         report_in.key_byte        = req_chan.key_byte;
         report_in.head_byte_three = req_chan.head_byte_three;
         report_in.arrival_ms      = req_chan.arrival_ms;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      report_ff <= report_in;
   end

   assign held_valid  = valid_ff;
   assign held_report = report_ff;

endmodule

/* hw/rtl/rkrf_filter_core.sv */
// ----------------------------------------------------------------------------
// rkrf_filter_core
// Header check, repeat detection and suppression decision for one report,
// with the key history state updated as a report with a good header is taken.
// ----------------------------------------------------------------------------
module rkrf_filter_core (
   input  logic                 clock,
   input  logic                 reset,
   input  rkrf_pkg::cfg_type    cfg,
   input  logic                 held_valid,
   input  rkrf_pkg::report_type held_report,
   input  logic                 slot_free,
   output logic                 take,
   output rkrf_pkg::result_type result
);

   logic [rkrf_pkg::KEY_W-1:0]   last_key_ff;
   logic [rkrf_pkg::KEY_W-1:0]   last_key_in;
   logic [rkrf_pkg::TIME_W-1:0]  last_seen_ff;
   logic [rkrf_pkg::TIME_W-1:0]  last_seen_in;
   logic [rkrf_pkg::TIME_W-1:0]  first_press_ff;
   logic [rkrf_pkg::TIME_W-1:0]  first_press_in;
   logic [rkrf_pkg::COUNT_W-1:0] repeats_ff;
   logic [rkrf_pkg::COUNT_W-1:0] repeats_in;

   logic                         header_ok;
   logic [rkrf_pkg::TIME_W-1:0]  window_end;
   logic [rkrf_pkg::TIME_W-1:0]  window_diff;
   logic [rkrf_pkg::TIME_W-1:0]  delay_end;
   logic [rkrf_pkg::TIME_W-1:0]  delay_diff;
   logic                         is_repeat;
   logic [rkrf_pkg::COUNT_W-1:0] repeats_next;
   logic                         suppress;
   logic                         emit;

   assign header_ok = (held_report.report_length == rkrf_pkg::GOOD_LENGTH)
                   && (held_report.head_byte_zero == rkrf_pkg::HEAD_ZERO)
                   && (held_report.head_byte_one == rkrf_pkg::HEAD_ONE)
                   && (held_report.head_byte_three == rkrf_pkg::HEAD_THREE);

   // wrap-aware compares: sign of the 32-bit difference
   assign window_end  = last_seen_ff + {16'd0, cfg.repeat_window_ms};
   assign window_diff = held_report.arrival_ms - window_end;
   assign delay_end   = first_press_ff + {16'd0, cfg.repeat_delay_ms};
   assign delay_diff  = held_report.arrival_ms - delay_end;

   assign is_repeat = (held_report.key_byte == last_key_ff) && window_diff[31];

   always_comb begin
      if (!is_repeat) begin
         repeats_next = '0;
      end else if (repeats_ff == rkrf_pkg::COUNT_MAX) begin
         repeats_next = repeats_ff;
      end else begin
         repeats_next = repeats_ff + 8'd1;
      end
   end

   assign suppress = is_repeat
                  && ((repeats_next < rkrf_pkg::MIN_REPEATS) || delay_diff[31]);
   assign emit     = header_ok && !suppress;
   assign take     = held_valid && (slot_free || !emit);

   assign result.load = take && emit;
   assign result.key  = held_report.key_byte;

   always_comb begin
      last_key_in    = last_key_ff;
      last_seen_in   = last_seen_ff;
      first_press_in = first_press_ff;
      repeats_in     = repeats_ff;
      if (take && header_ok) begin
         last_seen_in = held_report.arrival_ms;
         repeats_in   = repeats_next;
         if (!is_repeat) begin
            last_key_in    = held_report.key_byte;
            first_press_in = held_report.arrival_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_key_ff    <= '0;
         last_seen_ff   <= '0;
         first_press_ff <= '0;
         repeats_ff     <= '0;
      end else begin
         last_key_ff    <= last_key_in;
         last_seen_ff   <= last_seen_in;
         first_press_ff <= first_press_in;
         repeats_ff     <= repeats_in;
      end
   end

   a_bad_header_keeps_state: assert property (
      @(posedge clock) disable iff (reset)
      (take && !header_ok) |=> ($stable(last_key_ff) && $stable(repeats_ff)
                               && $stable(last_seen_ff) && $stable(first_press_ff))
   ) else $error("rejected report changed key history");

   a_new_press_restarts: assert property (
      @(posedge clock) disable iff (reset)
      (take && header_ok && !is_repeat) |=> ((repeats_ff == '0)
                                            && (first_press_ff == last_seen_ff))
   ) else $error("new press did not restart repeat tracking");

   a_repeat_counts_up: assert property (
      @(posedge clock) disable iff (reset)
      (take && header_ok && is_repeat && (repeats_ff != rkrf_pkg::COUNT_MAX))
         |=> (repeats_ff == $past(repeats_ff) + 8'd1)
   ) else $error("repeat count did not advance by one");

endmodule

/* hw/rtl/rkrf_output_stage.sv */
// ----------------------------------------------------------------------------
// rkrf_output_stage
// Result register: holds one key event until the response transfer.
// ----------------------------------------------------------------------------
module rkrf_output_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  rkrf_pkg::result_type result,
   output logic                 slot_free,
   rkrf_rsp_if.source           rsp_chan
);

   logic                       valid_ff;
   logic                       valid_in;
   logic [rkrf_pkg::KEY_W-1:0] key_ff;
   logic [rkrf_pkg::KEY_W-1:0] key_in;

   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (result.load) begin
         valid_in = 1'b1;
         key_in   = result.key;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.key_event = key_ff;

endmodule

/* hw/rtl/remote_key_repeat_filter.sv */
// path: input register, combinational filter core, result register
// throughput: one report per cycle while the response side keeps taking
// a response stall holds the result register, the report behind it waits in
// the input register and the request side sees ready drop
// reset: synchronous, clears valid flags and key history, loads the
// repeat window (300 ms) and repeat delay (500 ms)
// ----------------------------------------------------------------------------
// remote_key_repeat_filter
// Checks remote-control report headers and passes key presses on, holding
// back auto-repeats until enough repeats and the repeat delay have passed.
// ----------------------------------------------------------------------------
module remote_key_repeat_filter (
   input  logic                               clock,
   input  logic                               reset,
   rkrf_req_if.sink                           req_chan,
   rkrf_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [rkrf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rkrf_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   rkrf_pkg::cfg_type    cfg;
   logic                 held_valid;
   rkrf_pkg::report_type held_report;
   logic                 take;
   logic                 slot_free;
   rkrf_pkg::result_type result;

   rkrf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   rkrf_input_stage u_input_stage (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .take        (take),
      .held_valid  (held_valid),
      .held_report (held_report)
   );

   rkrf_filter_core u_filter_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .held_valid  (held_valid),
      .held_report (held_report),
      .slot_free   (slot_free),
      .take        (take),
      .result      (result)
   );

   rkrf_output_stage u_output_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Regression for the remote key repeat filter. A short table of header and
// timing corner cases comes first. Random report streams follow under several
// repeat window and delay settings, held-key runs among them. Every key event
// is checked against the table's expected event or a behavioral model of the
// filter while the request side idles between bursts and the response side stalls.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam int unsigned SETTLE_CYCLES    = 4;
   localparam int unsigned PHASE_COUNT      = 8;
   localparam int unsigned RANDOM_PER_PHASE = 180;
   localparam int unsigned HELD_RUN_LENGTH  = 260;
   localparam int unsigned PRINT_LIMIT      = 30;
   localparam logic [rkrf_pkg::CSR_INDEX_W-1:0] CSR_INDEX_SPARE = 8'd2;
   localparam logic [rkrf_pkg::CSR_INDEX_W-1:0] CSR_INDEX_TOP   = 8'hff;

   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_COIN,
      DRAIN_QUARTER,
      DRAIN_SPARSE
   } drain_mode_type;

   typedef struct {
      rkrf_pkg::report_type           report;
      bit                             typed;
      bit                             emits;
      logic [rkrf_pkg::KEY_W-1:0]     key;
   } directed_row_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_write_enable;
   logic [rkrf_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rkrf_pkg::CSR_DATA_W-1:0]  csr_write_data;

   rkrf_req_if req_if ();
   rkrf_rsp_if rsp_if ();

   remote_key_repeat_filter dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // filter model state and settings
   logic [rkrf_pkg::CSR_DATA_W-1:0] window_cfg;
   logic [rkrf_pkg::CSR_DATA_W-1:0] delay_cfg;
   logic [rkrf_pkg::KEY_W-1:0]      held_key;
   logic [rkrf_pkg::TIME_W-1:0]     held_seen_ms;
   logic [rkrf_pkg::TIME_W-1:0]     press_start_ms;
   logic [rkrf_pkg::COUNT_W-1:0]    repeat_run;

   logic [rkrf_pkg::KEY_W-1:0] pending_keys[$];
   logic [rkrf_pkg::KEY_W-1:0] wanted_key;
   directed_row_type           directed_rows[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned reports_sent = 0;
   int unsigned keys_checked = 0;
   int unsigned settings_applied = 0;
   int unsigned spare_writes = 0;
   int unsigned saturated_hits = 0;
   int unsigned burst_left = 0;
   logic [rkrf_pkg::TIME_W-1:0] now_ms;
   logic [rkrf_pkg::KEY_W-1:0]  cur_key;

   drain_mode_type drain_mode = DRAIN_FREE;
   int unsigned    drain_left = 0;

   task automatic report_error(input string what);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic bit is_before(input logic [rkrf_pkg::TIME_W-1:0] a,
                                    input logic [rkrf_pkg::TIME_W-1:0] b);
      logic [rkrf_pkg::TIME_W-1:0] diff;
      diff = a - b;
      return diff[rkrf_pkg::TIME_W-1];
   endfunction

   function automatic void reset_filter_model();
      window_cfg     = rkrf_pkg::REPEAT_WINDOW_RESET;
      delay_cfg      = rkrf_pkg::REPEAT_DELAY_RESET;
      held_key       = '0;
      held_seen_ms   = '0;
      press_start_ms = '0;
      repeat_run     = '0;
   endfunction

   // advances the model by one report, returns 1 when a key event follows
   function automatic bit filter_key(input rkrf_pkg::report_type r,
                                     output logic [rkrf_pkg::KEY_W-1:0] key_out);
      logic [rkrf_pkg::TIME_W-1:0] window_end;
      logic [rkrf_pkg::TIME_W-1:0] delay_end;
      key_out = r.key_byte;
      if (r.report_length != rkrf_pkg::GOOD_LENGTH ||
          r.head_byte_zero != rkrf_pkg::HEAD_ZERO ||
          r.head_byte_one != rkrf_pkg::HEAD_ONE ||
          r.head_byte_three != rkrf_pkg::HEAD_THREE)
         return 1'b0;
      window_end = held_seen_ms + 32'(window_cfg);
      if (r.key_byte == held_key && is_before(r.arrival_ms, window_end)) begin
         if (repeat_run != rkrf_pkg::COUNT_MAX)
            repeat_run = repeat_run + 1'b1;
         else
            saturated_hits++;
      end else begin
         repeat_run     = '0;
         press_start_ms = r.arrival_ms;
         held_key       = r.key_byte;
      end
      held_seen_ms = r.arrival_ms;
      delay_end = press_start_ms + 32'(delay_cfg);
      if (repeat_run != '0 &&
          (repeat_run < rkrf_pkg::MIN_REPEATS || is_before(r.arrival_ms, delay_end)))
         return 1'b0;
      return 1'b1;
   endfunction

   function automatic void add_row(input logic [rkrf_pkg::LENGTH_W-1:0] len,
                                   input logic [7:0] b0, input logic [7:0] b1,
                                   input logic [rkrf_pkg::KEY_W-1:0] key,
                                   input logic [7:0] b3,
                                   input logic [rkrf_pkg::TIME_W-1:0] at,
                                   input bit typed, input bit emits);
      directed_row_type row;
      row.report = '{len, b0, b1, key, b3, at};
      row.typed  = typed;
      row.emits  = emits;
      row.key    = key;
      directed_rows.push_back(row);
   endfunction

   function automatic void build_directed_table();
      // key zero right after reset looks like a repeat of the cleared history
      add_row(6'd6,  8'h00, 8'h06, 8'h00, 8'h0a, 32'd100, 1'b0, 1'b0);
      // header rejects
      add_row(6'd5,  8'h00, 8'h06, 8'h12, 8'h0a, 32'd200, 1'b1, 1'b0);
      add_row(6'd63, 8'h00, 8'h06, 8'h12, 8'h0a, 32'd210, 1'b1, 1'b0);
      add_row(6'd0,  8'h00, 8'h06, 8'h12, 8'h0a, 32'd220, 1'b1, 1'b0);
      add_row(6'd6,  8'hff, 8'h06, 8'h12, 8'h0a, 32'd230, 1'b1, 1'b0);
      add_row(6'd6,  8'h00, 8'hff, 8'h12, 8'h0a, 32'd240, 1'b1, 1'b0);
      add_row(6'd6,  8'h00, 8'h06, 8'h12, 8'hff, 32'd250, 1'b1, 1'b0);
      add_row(6'd6,  8'h00, 8'h06, 8'h12, 8'h0b, 32'd260, 1'b1, 1'b0);
      // new press, then repeats up to and across the delay edge
      add_row(6'd6,  8'h00, 8'h06, 8'h12, 8'h0a, 32'd1000, 1'b1, 1'b1);
      add_row(6'd6,  8'h00, 8'h06, 8'h12, 8'h0a, 32'd1100, 1'b0, 1'b0);
      add_row(6'd6,  8'h00, 8'h06, 8'h12, 8'h0a, 32'd1200, 1'b0, 1'b0);
      add_row(6'd6,  8'h00, 8'h06, 8'h12, 8'h0a, 32'd1300, 1'b0, 1'b0);
      add_row(6'd6,  8'h00, 8'h06, 8'h12, 8'h0a, 32'd1400, 1'b0, 1'b0);
      add_row(6'd6,  8'h00, 8'h06, 8'h12, 8'h0a, 32'd1450, 1'b0, 1'b0);
      add_row(6'd6,  8'h00, 8'h06, 8'h12, 8'h0a, 32'd1500, 1'b0, 1'b0);
      // gap exactly at the window edge
      add_row(6'd6,  8'h00, 8'h06, 8'h12, 8'h0a, 32'd1800, 1'b0, 1'b0);
      // timestamp wrap
      add_row(6'd6,  8'h00, 8'h06, 8'hff, 8'h0a, 32'hffff_fff0, 1'b1, 1'b1);
      add_row(6'd6,  8'h00, 8'h06, 8'hff, 8'h0a, 32'hffff_ffff, 1'b0, 1'b0);
      add_row(6'd6,  8'h00, 8'h06, 8'hff, 8'h0a, 32'h0000_0010, 1'b0, 1'b0);
      // signed midpoint of the time compare
      add_row(6'd6,  8'h00, 8'h06, 8'h00, 8'h0a, 32'h7fff_ffff, 1'b1, 1'b1);
      add_row(6'd6,  8'h00, 8'hff, 8'h00, 8'h0a, 32'h8000_0000, 1'b1, 1'b0);
      add_row(6'd6,  8'h00, 8'h06, 8'h00, 8'h0a, 32'h8000_0000, 1'b0, 1'b0);
      add_row(6'd63, 8'hff, 8'hff, 8'hff, 8'hff, 32'hffff_ffff, 1'b1, 1'b0);
      add_row(6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 1'b1, 1'b0);
   endfunction

   function automatic rkrf_pkg::report_type random_report();
      rkrf_pkg::report_type r;
      int unsigned          roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         r.report_length   = 6'($urandom);
         r.head_byte_zero  = 8'($urandom);
         r.head_byte_one   = 8'($urandom);
         r.key_byte        = 8'($urandom);
         r.head_byte_three = 8'($urandom);
         r.arrival_ms      = $urandom;
         return r;
      end
      case ($urandom_range(0, 9))
         0, 1: cur_key = 8'($urandom_range(0, 255));
         2: cur_key = 8'($urandom_range(0, 3));
         default: ;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 55)
         now_ms = now_ms + $urandom_range(0, 180);
      else if (roll < 80)
         now_ms = now_ms + $urandom_range(150, 1500);
      else if (roll < 90)
         now_ms = now_ms - $urandom_range(1, 400);
      else
         now_ms = $urandom;
      r = '{rkrf_pkg::GOOD_LENGTH, rkrf_pkg::HEAD_ZERO, rkrf_pkg::HEAD_ONE, cur_key,
            rkrf_pkg::HEAD_THREE, now_ms};
      // a well-formed report with one header field broken
      if ($urandom_range(0, 99) < 8) begin
         case ($urandom_range(0, 3))
            0: r.report_length = r.report_length ^ 6'($urandom_range(1, 63));
            1: r.head_byte_zero = r.head_byte_zero ^ 8'($urandom_range(1, 255));
            2: r.head_byte_one = r.head_byte_one ^ 8'($urandom_range(1, 255));
            default: r.head_byte_three = r.head_byte_three ^ 8'($urandom_range(1, 255));
         endcase
      end
      return r;
   endfunction

   function automatic rkrf_pkg::report_type held_report();
      now_ms = now_ms + $urandom_range(1, 40);
      return '{rkrf_pkg::GOOD_LENGTH, rkrf_pkg::HEAD_ZERO, rkrf_pkg::HEAD_ONE, cur_key,
               rkrf_pkg::HEAD_THREE, now_ms};
   endfunction

   task automatic send_report(input rkrf_pkg::report_type r, input bit typed,
                              input bit emits,
                              input logic [rkrf_pkg::KEY_W-1:0] typed_key);
      int unsigned                gap;
      logic [rkrf_pkg::KEY_W-1:0] key;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid           <= 1'b1;
      req_if.report_length   <= r.report_length;
      req_if.head_byte_zero  <= r.head_byte_zero;
      req_if.head_byte_one   <= r.head_byte_one;
      req_if.key_byte        <= r.key_byte;
      req_if.head_byte_three <= r.head_byte_three;
      req_if.arrival_ms      <= r.arrival_ms;
      do @(posedge clock); while (!req_if.ready);
      reports_sent++;
      if (filter_key(r, key) && !typed)
         pending_keys.push_back(key);
      if (typed && emits)
         pending_keys.push_back(typed_key);
   endtask

   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_register(input logic [rkrf_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [rkrf_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      if (index == rkrf_pkg::CSR_REPEAT_WINDOW)
         window_cfg = value;
      else if (index == rkrf_pkg::CSR_REPEAT_DELAY)
         delay_cfg = value;
      else
         spare_writes++;
   endtask

   task automatic apply_phase_settings(input int unsigned phase);
      case (phase)
         1: begin
            write_register(rkrf_pkg::CSR_REPEAT_WINDOW, 16'hffff);
            write_register(rkrf_pkg::CSR_REPEAT_DELAY, 16'h0000);
         end
         2: begin
            write_register(rkrf_pkg::CSR_REPEAT_WINDOW, 16'h0000);
            write_register(rkrf_pkg::CSR_REPEAT_DELAY, 16'hffff);
         end
         3: begin
            write_register(rkrf_pkg::CSR_REPEAT_DELAY, 16'h0000);
         end
         4: begin
            write_register(rkrf_pkg::CSR_REPEAT_WINDOW, 16'hffff);
            write_register(rkrf_pkg::CSR_REPEAT_DELAY, 16'hffff);
         end
         5: begin
            write_register(rkrf_pkg::CSR_REPEAT_WINDOW, 16'($urandom_range(1, 1000)));
            write_register(rkrf_pkg::CSR_REPEAT_DELAY, 16'($urandom_range(0, 2000)));
            // writes to unmapped indexes must leave both settings alone
            write_register(CSR_INDEX_SPARE, 16'($urandom));
            write_register(CSR_INDEX_TOP, 16'($urandom));
         end
         6: begin
            write_register(rkrf_pkg::CSR_REPEAT_WINDOW, 16'd1);
            write_register(rkrf_pkg::CSR_REPEAT_DELAY, 16'd1);
         end
         7: begin
            write_register(rkrf_pkg::CSR_REPEAT_WINDOW, 16'($urandom_range(100, 600)));
            write_register(rkrf_pkg::CSR_REPEAT_DELAY, 16'($urandom_range(200, 1200)));
         end
         default: ;
      endcase
      if (phase != 0)
         csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   // response side stalls on a pattern picked at random: free, coin, quarter or sparse
   always @(posedge clock) begin
      if (drain_left == 0) begin
         drain_mode <= drain_mode_type'($urandom_range(0, 3));
         drain_left <= $urandom_range(20, 200);
      end else begin
         drain_left <= drain_left - 1;
      end
      case (drain_mode)
         DRAIN_FREE: rsp_if.ready <= 1'b1;
         DRAIN_COIN: rsp_if.ready <= 1'($urandom_range(0, 1));
         DRAIN_QUARTER: rsp_if.ready <= (drain_left[1:0] == 2'b00);
         default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // key event check on every response transfer
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_keys.size() == 0) begin
            report_error($sformatf("key event %02h with nothing expected",
                                   rsp_if.key_event));
         end else begin
            wanted_key = pending_keys.pop_front();
            keys_checked++;
            if (rsp_if.key_event !== wanted_key)
               report_error($sformatf("key_event %02h, expected %02h",
                                      rsp_if.key_event, wanted_key));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d key events outstanding",
                  cycle_count, pending_keys.size());
         $display("remote_key_repeat_filter regression: fail");
         $finish;
      end
   end

   initial begin
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_index              = '0;
      csr_write_data         = '0;
      req_if.valid           = 1'b0;
      req_if.report_length   = '0;
      req_if.head_byte_zero  = '0;
      req_if.head_byte_one   = '0;
      req_if.key_byte        = '0;
      req_if.head_byte_three = '0;
      req_if.arrival_ms      = '0;
      rsp_if.ready           = 1'b0;
      reset_filter_model();
      build_directed_table();
      now_ms  = 32'h8000_1000;
      cur_key = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_report(directed_rows[i].report, directed_rows[i].typed,
                     directed_rows[i].emits, directed_rows[i].key);

      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         hold_until_drained();
         apply_phase_settings(phase);
         // held key long enough to saturate the repeat count
         if (phase == 1 || phase == 4) begin
            cur_key = 8'($urandom_range(0, 255));
            for (int unsigned n = 0; n < HELD_RUN_LENGTH; n++)
               send_report(held_report(), 1'b0, 1'b0, '0);
         end
         for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_report(random_report(), 1'b0, 1'b0, '0);
            if ($urandom_range(0, 149) == 0)
               hold_until_drained();
         end
      end
      hold_until_drained();

      $display("covered %0d reports (%0d directed) under %0d register settings",
               reports_sent, directed_rows.size(), settings_applied);
      $display("%0d key events checked, repeat count held at saturation %0d times",
               keys_checked, saturated_hits);
      $display("%0d unmapped register writes", spare_writes);
      if (error_count == 0)
         $display("remote_key_repeat_filter regression: pass");
      else
         $display("remote_key_repeat_filter regression: fail");
      $finish;
   end

endmodule

/* remote_key_repeat_filter.f */
hw/rtl/rkrf_pkg.sv
hw/rtl/rkrf_channels.sv
hw/rtl/rkrf_csr.sv
hw/rtl/rkrf_input_stage.sv
hw/rtl/rkrf_filter_core.sv
hw/rtl/rkrf_output_stage.sv
hw/rtl/remote_key_repeat_filter.sv
test/tb_top.sv
